[design/lzd_pkg.sv]
`default_nettype none

package lzd_pkg;

    // adaptive split of the 16-bit token
    localparam int TOKEN_BITS = 16;
    localparam int MIN_SHIFT  = 4;
    localparam int SCAN_BITS  = TOKEN_BITS - MIN_SHIFT;
    localparam int SHIFT_W    = 5;
    localparam int DIST_W     = TOKEN_BITS - MIN_SHIFT + 1;
    localparam int ITEMS      = 8;

    // parser phases
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    // request kinds
    localparam logic REQ_FEED = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PENDING = 3'd1;
    localparam logic [2:0] ST_NO_COPY = 3'd2;
    localparam logic [2:0] ST_BAD_DIST = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } in_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic [15:0] copy_left;
        logic        finished;
        logic [2:0]  status;
    } out_t;

endpackage

`default_nettype wire

[design/lzd_hist.sv]
`default_nettype none

// History ring: one write port, one registered read port, write-first on a
// same-address collision so a byte written this cycle is seen by the read.
module lzd_hist #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/lz77_adaptive_offset_decoder.sv]
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+----------------------------
// in        | to block  | in_valid / in_stall   | in_data  (lzd_pkg::in_t)
// out       | from block| out_valid / out_stall | out_data (lzd_pkg::out_t)
// cfg       | to block  | cfg_we                | cfg_wdata (out_length)
//
// One request and one result per cycle while out_stall is low.
// Parser state updates at input transfer; the history read is issued then and
// the resolve stage takes the byte from its registered data and writes it back.
// A pull right behind the byte it copies is served by the write-first bypass.
// in_stall is high only while both stages are full and out_stall holds the output.
// rst_n clears all control state; the history ring holds no reset value.
`default_nettype none

module lz77_adaptive_offset_decoder #(
    parameter int WINDOW_BYTES = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire lzd_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output lzd_pkg::out_t      out_data,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int EW = AW + 1;

    // parser / copy state
    logic [31:0]               count_reg, count_next;
    logic [1:0]                phase_reg, phase_next;
    logic [7:0]                flags_reg, flags_next;
    logic [2:0]                idx_reg, idx_next;
    logic [7:0]                tlow_reg, tlow_next;
    logic [15:0]               remain_reg, remain_next;
    logic [lzd_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [AW-1:0]             wptr_reg, wptr_next;
    logic [31:0]               out_length_reg;

    // resolve stage
    logic                      p_valid_reg;
    logic                      p_emit_reg;
    logic                      p_pull_reg;
    logic [7:0]                p_lit_reg;
    logic [AW-1:0]             p_waddr_reg;
    logic [15:0]               p_left_reg;
    logic                      p_finished_reg;
    logic [2:0]                p_status_reg;

    // output stage
    logic                      out_valid_reg;
    lzd_pkg::out_t             out_data_reg;

    logic                      p_move, ready, accept;
    logic                      done_now, emit, from_mem;
    logic [7:0]                lit;
    logic [2:0]                status;
    logic [15:0]               token;
    logic [3:0]                blen;
    logic [lzd_pkg::SHIFT_W-1:0] shift;
    logic [16:0]               mask;
    logic [15:0]               len;
    logic [lzd_pkg::DIST_W-1:0] tok_dist;
    logic [EW-1:0]             ptr_ext, dist_ext;
    logic [AW-1:0]             raddr;
    logic [7:0]                rdata;
    logic [7:0]                p_byte;
    logic                      hist_we;

    assign p_move   = !out_valid_reg || !out_stall;
    assign ready    = !p_valid_reg || p_move;
    assign in_stall = !ready;
    assign accept   = in_valid && ready;

    // bit length of the low SCAN_BITS of the count; a higher set bit forces MIN_SHIFT
    always_comb
    begin
        blen = '0;
        for (int i = 0; i < lzd_pkg::SCAN_BITS; i++)
        begin
            if (count_reg[i])
            begin
                blen = 4'(i + 1);
            end
        end
        if ((|count_reg[31:lzd_pkg::SCAN_BITS]) || (blen >= 4'(lzd_pkg::SCAN_BITS)))
        begin
            shift = lzd_pkg::SHIFT_W'(lzd_pkg::MIN_SHIFT);
        end
        else
        begin
            shift = lzd_pkg::SHIFT_W'(lzd_pkg::TOKEN_BITS) - lzd_pkg::SHIFT_W'(blen);
        end
    end

    assign token    = {in_data.in_byte, tlow_reg};
    assign mask     = (17'd1 << shift) - 17'd1;
    assign len      = token & mask[15:0];
    assign tok_dist = lzd_pkg::DIST_W'(token >> shift) + lzd_pkg::DIST_W'(1);

    // copy source: write pointer minus distance, modulo the window
    assign ptr_ext  = {1'b0, wptr_reg};
    assign dist_ext = EW'(dist_reg);
    always_comb
    begin
        if (ptr_ext >= dist_ext)
        begin
            raddr = AW'(ptr_ext - dist_ext);
        end
        else
        begin
            raddr = AW'(ptr_ext + EW'(WINDOW_BYTES) - dist_ext);
        end
    end

    assign done_now = count_reg >= out_length_reg;

    always_comb
    begin
        emit        = 1'b0;
        from_mem    = 1'b0;
        lit         = '0;
        status      = lzd_pkg::ST_OK;
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        idx_next    = idx_reg;
        tlow_next   = tlow_reg;
        remain_next = remain_reg;
        dist_next   = dist_reg;

        priority if (done_now)
        begin
            status = lzd_pkg::ST_FINISHED;
        end
        else if (in_data.req_type == lzd_pkg::REQ_PULL)
        begin
            if (remain_reg == '0)
            begin
                status = lzd_pkg::ST_NO_COPY;
            end
            else
            begin
                emit        = 1'b1;
                from_mem    = 1'b1;
                remain_next = remain_reg - 16'd1;
            end
        end
        else if (remain_reg != '0)
        begin
            status = lzd_pkg::ST_PENDING;
        end
        else
        begin
            unique case (phase_reg)
                lzd_pkg::PH_ITEM:
                begin
                    if (!flags_reg[idx_reg])
                    begin
                        emit = 1'b1;
                        lit  = in_data.in_byte;
                        if (idx_reg == 3'(lzd_pkg::ITEMS - 1))
                        begin
                            idx_next   = '0;
                            phase_next = lzd_pkg::PH_FLAG;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 3'd1;
                            phase_next = lzd_pkg::PH_ITEM;
                        end
                    end
                    else
                    begin
                        tlow_next  = in_data.in_byte;
                        phase_next = lzd_pkg::PH_HIGH;
                    end
                end
                lzd_pkg::PH_HIGH:
                begin
                    if ((32'(tok_dist) > count_reg) || (32'(tok_dist) > 32'(WINDOW_BYTES)))
                    begin
                        status = lzd_pkg::ST_BAD_DIST;
                    end
                    else if (len != '0)
                    begin
                        remain_next = len;
                        dist_next   = tok_dist;
                    end
                    if (idx_reg == 3'(lzd_pkg::ITEMS - 1))
                    begin
                        idx_next   = '0;
                        phase_next = lzd_pkg::PH_FLAG;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        phase_next = lzd_pkg::PH_ITEM;
                    end
                end
                default:
                begin
                    flags_next = in_data.in_byte;
                    idx_next   = '0;
                    phase_next = lzd_pkg::PH_ITEM;
                end
            endcase
        end

        count_next = count_reg + 32'(emit);
        // reaching the end drops the rest of a copy
        if (emit && (count_next >= out_length_reg))
        begin
            remain_next = '0;
        end

        if (emit)
        begin
            wptr_next = (wptr_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wptr_reg + AW'(1);
        end
        else
        begin
            wptr_next = wptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            phase_reg      <= lzd_pkg::PH_FLAG;
            flags_reg      <= '0;
            idx_reg        <= '0;
            tlow_reg       <= '0;
            remain_reg     <= '0;
            dist_reg       <= '0;
            wptr_reg       <= '0;
            out_length_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                out_length_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg  <= count_next;
                phase_reg  <= phase_next;
                flags_reg  <= flags_next;
                idx_reg    <= idx_next;
                tlow_reg   <= tlow_next;
                remain_reg <= remain_next;
                dist_reg   <= dist_next;
                wptr_reg   <= wptr_next;
            end
        end
    end

    // resolve stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            p_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_emit_reg     <= emit;
            p_pull_reg     <= from_mem;
            p_lit_reg      <= lit;
            p_waddr_reg    <= wptr_reg;
            p_left_reg     <= remain_next;
            p_finished_reg <= count_next >= out_length_reg;
            p_status_reg   <= status;
        end
    end

    assign p_byte  = p_pull_reg ? rdata : p_lit_reg;
    assign hist_we = p_valid_reg && p_move && p_emit_reg;

    lzd_hist #(
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (p_waddr_reg),
        .wdata (p_byte),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p_move)
        begin
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_move && p_valid_reg)
        begin
            out_data_reg.byte_valid <= p_emit_reg;
            out_data_reg.out_byte   <= p_byte;
            out_data_reg.copy_left  <= p_left_reg;
            out_data_reg.finished   <= p_finished_reg;
            out_data_reg.status     <= p_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_wptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg <= AW'(WINDOW_BYTES - 1))
        else $error("history write pointer outside the window");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (p_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_pull_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.req_type == lzd_pkg::REQ_PULL) && !done_now &&
         (remain_reg != '0)) |=> (p_valid_reg && p_emit_reg && p_pull_reg))
        else $error("pending copy byte not produced");

    a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_emit_reg) |-> (p_status_reg == lzd_pkg::ST_OK))
        else $error("byte produced with error status");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("output count did not advance");

endmodule

`default_nettype wire
